>>> rtl/escape_time_fractal_pixel_unit_defines.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// disabled while rst_ni is low.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_UNIT_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define EFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/efp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package efp_pkg;

  localparam int COORD_W = 10;
  localparam int COUNT_W = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int SAT_W   = 48;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  // 4.0 in Q8.56
  localparam logic [64:0] ESC_BOUND = 65'd4 << 56;

  typedef enum logic [2:0] {
    REG_KIND        = 3'd0,
    REG_CENTER_REAL = 3'd1,
    REG_CENTER_IMAG = 3'd2,
    REG_PIXEL_STEP  = 3'd3,
    REG_JULIA_REAL  = 3'd4,
    REG_JULIA_IMAG  = 3'd5,
    REG_ITER_LIMIT  = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAP1 = 5'b00010,
    ST_MAP2 = 5'b00100,
    ST_SQR  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_e;

  typedef struct packed {
    logic                fractal_kind;
    logic signed [31:0]  center_real;
    logic signed [31:0]  center_imag;
    logic [30:0]         pixel_step;
    logic signed [31:0]  julia_c_real;
    logic signed [31:0]  julia_c_imag;
    logic [COUNT_W-1:0]  iteration_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fractal_kind:    1'b1,
    center_real:     32'sd0,
    center_imag:     32'sd0,
    pixel_step:      31'd1048576,
    julia_c_real:    32'sd0,
    julia_c_imag:    32'sd0,
    iteration_limit: 16'd100
  };

  typedef struct packed {
    logic load;
    logic map_y;
    logic seed;
    logic square;
    logic update;
    logic emit;
    logic escaped;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic fixed;
    logic last;
  } sts_t;

  // Clamp a wide signed value to the Q4.28 range.
  function automatic logic signed [31:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic all_ones;
    logic all_zeros;
    all_ones  = &v[SAT_W-1:31];
    all_zeros = ~|v[SAT_W-1:31];
    if (all_ones || all_zeros) begin
      return v[31:0];
    end else if (v[SAT_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/efp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module efp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efp_pkg::ADDR_W-1:0]   paddr,
  input  logic [efp_pkg::DATA_W-1:0]   pwdata,
  output logic [efp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output efp_pkg::cfg_t                cfg_o
);
  import efp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_KIND:        cfg_q.fractal_kind    <= pwdata[0];
        REG_CENTER_REAL: cfg_q.center_real     <= $signed(pwdata);
        REG_CENTER_IMAG: cfg_q.center_imag     <= $signed(pwdata);
        REG_PIXEL_STEP:  cfg_q.pixel_step      <= pwdata[30:0];
        REG_JULIA_REAL:  cfg_q.julia_c_real    <= $signed(pwdata);
        REG_JULIA_IMAG:  cfg_q.julia_c_imag    <= $signed(pwdata);
        REG_ITER_LIMIT:  cfg_q.iteration_limit <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KIND:        prdata = {{(DATA_W-1){1'b0}}, cfg_q.fractal_kind};
      REG_CENTER_REAL: prdata = cfg_q.center_real;
      REG_CENTER_IMAG: prdata = cfg_q.center_imag;
      REG_PIXEL_STEP:  prdata = {1'b0, cfg_q.pixel_step};
      REG_JULIA_REAL:  prdata = cfg_q.julia_c_real;
      REG_JULIA_IMAG:  prdata = cfg_q.julia_c_imag;
      REG_ITER_LIMIT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_q.iteration_limit};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/efp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module efp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  efp_pkg::sts_t sts_i,
  output efp_pkg::cmd_t cmd_o
);
  import efp_pkg::*;
  `include "escape_time_fractal_pixel_unit_defines.svh"

  state_e state_q;
  state_e state_d;

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MAP1;
        end
      end
      ST_MAP1: begin
        cmd_o.map_y = 1'b1;
        state_d     = ST_MAP2;
      end
      ST_MAP2: begin
        cmd_o.seed = 1'b1;
        if (sts_i.limit_zero) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        // escape is tested on the old z, before the fixed-point check
        if (sts_i.escape) begin
          cmd_o.emit    = 1'b1;
          cmd_o.escaped = 1'b1;
          state_d       = ST_IDLE;
        end else if (sts_i.fixed || sts_i.last) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = ST_SQR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `EFP_ASSERT_NEXT(a_accept_maps, start && !busy, state_q == ST_MAP1)
  `EFP_ASSERT_NEXT(a_emit_idle, cmd_o.emit, state_q == ST_IDLE)
  `EFP_ASSERT_IMPL(a_update_after_square, cmd_o.update, $past(cmd_o.square))

endmodule
`default_nettype wire

>>> rtl/efp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module efp_dp #(
  parameter int IMAGE_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  efp_pkg::cmd_t                 cmd_i,
  input  efp_pkg::cfg_t                 cfg_i,
  input  logic [efp_pkg::COORD_W-1:0]   pixel_x_i,
  input  logic [efp_pkg::COORD_W-1:0]   pixel_y_i,
  output efp_pkg::sts_t                 sts_o,
  output logic                          done_o,
  output logic [efp_pkg::COUNT_W-1:0]   escape_count_o
);
  import efp_pkg::*;
  `include "escape_time_fractal_pixel_unit_defines.svh"

  // signed offset width: holds coord - IMAGE_WIDTH/2 over the whole range
  localparam int DW = (($clog2(IMAGE_WIDTH) > COORD_W) ? $clog2(IMAGE_WIDTH) : COORD_W) + 1;
  localparam int PW = DW + 32;
  localparam int SW = PW + 1;
  localparam logic signed [DW-1:0] HALF = DW'(IMAGE_WIDTH / 2);

  logic [COORD_W-1:0]   y_q;
  logic signed [DW-1:0] dx, dy, dsel;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [31:0]   csel;
  logic signed [SW-1:0] msum;
  logic signed [31:0]   mapped, px_q;

  logic signed [31:0]   zr_q, zi_q, cr_q, ci_q;
  logic signed [63:0]   sr_q, si_q, xp_q;
  logic signed [63:0]   diff;
  logic [64:0]          mag;
  logic signed [37:0]   nr_sum, ni_sum;
  logic signed [31:0]   nr, ni;
  logic [COUNT_W-1:0]   iter_q;
  logic                 done_q;
  logic [COUNT_W-1:0]   count_q;

  // coordinate mapping: one shared multiplier, x then y
  assign dx     = $signed({{(DW-COORD_W){1'b0}}, pixel_x_i}) - HALF;
  assign dy     = $signed({{(DW-COORD_W){1'b0}}, y_q}) - HALF;
  assign dsel   = cmd_i.load ? dx : dy;
  assign prod_d = dsel * $signed({1'b0, cfg_i.pixel_step});
  assign csel   = cmd_i.map_y ? cfg_i.center_real : cfg_i.center_imag;
  assign msum   = $signed({prod_q[PW-1], prod_q}) + $signed({{(SW-32){csel[31]}}, csel});
  assign mapped = sat_q($signed({{(SAT_W-SW){msum[SW-1]}}, msum}));

  // iteration update from the registered products
  assign mag    = {1'b0, sr_q} + {1'b0, si_q};
  assign diff   = sr_q - si_q;
  assign nr_sum = $signed({{2{diff[63]}}, diff[63:28]}) + $signed({{6{cr_q[31]}}, cr_q});
  assign ni_sum = $signed({xp_q[63], xp_q[63:27]}) + $signed({{6{ci_q[31]}}, ci_q});
  assign nr     = sat_q($signed({{(SAT_W-38){nr_sum[37]}}, nr_sum}));
  assign ni     = sat_q($signed({{(SAT_W-38){ni_sum[37]}}, ni_sum}));

  assign sts_o.limit_zero = (cfg_i.iteration_limit == '0);
  assign sts_o.escape     = (mag > ESC_BOUND);
  assign sts_o.fixed      = (nr == zr_q) && (ni == zi_q);
  assign sts_o.last       = (iter_q == cfg_i.iteration_limit);

  assign done_o         = done_q;
  assign escape_count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      y_q <= pixel_y_i;
    end
    if (cmd_i.load || cmd_i.map_y) begin
      prod_q <= prod_d;
    end
    if (cmd_i.map_y) begin
      px_q <= mapped;
    end
    if (cmd_i.seed) begin
      if (cfg_i.fractal_kind) begin
        cr_q <= px_q;
        ci_q <= mapped;
        zr_q <= '0;
        zi_q <= '0;
      end else begin
        zr_q <= px_q;
        zi_q <= mapped;
        cr_q <= cfg_i.julia_c_real;
        ci_q <= cfg_i.julia_c_imag;
      end
    end
    if (cmd_i.square) begin
      sr_q <= zr_q * zr_q;
      si_q <= zi_q * zi_q;
      xp_q <= zr_q * zi_q;
    end
    if (cmd_i.update) begin
      zr_q <= nr;
      zi_q <= ni;
    end
    if (cmd_i.emit) begin
      count_q <= cmd_i.escaped ? iter_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.seed) begin
        iter_q <= COUNT_W'(1);
      end else if (cmd_i.update) begin
        iter_q <= iter_q + COUNT_W'(1);
      end
    end
  end

  `EFP_ASSERT_NEXT(a_done_single, done_q, !done_q)
  `EFP_ASSERT_IMPL(a_count_needs_escape, done_q && (count_q != '0), $past(cmd_i.escaped))
  `EFP_ASSERT_IMPL(a_iter_nonzero, cmd_i.square, iter_q != '0)

endmodule
`default_nettype wire

>>> rtl/escape_time_fractal_pixel_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Per request: coordinate mapping (MAP1, MAP2), then a square step and an update
//   step per iteration run; the iteration runs top out at iteration_limit.
// A new request is taken only while busy is low, once the previous pixel is finished.
// Reset (rst_ni low, asynchronous): controller idle, no result pending,
//   registers back to Mandelbrot, centre 0, step 2^-8, limit 100.
// Results are strobed for one cycle; the receiver cannot stall.
module escape_time_fractal_pixel_unit #(
  parameter int IMAGE_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [efp_pkg::COORD_W-1:0]   pixel_x_i,
  input  logic [efp_pkg::COORD_W-1:0]   pixel_y_i,
  // result channel
  output logic                          done_o,
  output logic [efp_pkg::COUNT_W-1:0]   escape_count_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efp_pkg::ADDR_W-1:0]    paddr,
  input  logic [efp_pkg::DATA_W-1:0]    pwdata,
  output logic [efp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import efp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Register file: one 32-bit word per register, byte address 4*index.
  // Writes land on the access phase; reads are combinational.
  efp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: accept, map x, map y and seed z/c, then, unless the iteration limit is zero,
  // alternate square and update until escape, a fixed point or the iteration limit.
  efp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: one shared multiplier for the mapping, three 32x32 products
  // per iteration, saturating Q4.28 update and the result register.
  efp_dp #(
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .sts_o          (sts),
    .done_o         (done_o),
    .escape_count_o (escape_count_o)
  );

endmodule
`default_nettype wire
